>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the RTT timeout estimator.
// Synthesis builds see empty bodies; simulation builds see concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/rte_pkg.sv
// Package of the RTT timeout estimator: widths, register indexes, reset values,
// the divide-by-ten reciprocal and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rte_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_RTO_MIN = 2'd1;
	localparam logic [1:0] REG_RTO_MAX = 2'd2;

	// configuration reset values, ms
	localparam logic [15:0] RTO_MIN_RST = 16'd200;
	localparam logic [15:0] RTO_MAX_RST = 16'd20000;

	// divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2**22
	localparam int unsigned SUM_W       = 20;
	localparam int unsigned RECIP_SHIFT = 23;
	localparam logic [SUM_W-1:0] RECIP_TEN = 20'd838861;
	localparam int unsigned QUO_W       = 2 * SUM_W - RECIP_SHIFT;

	// one timing sample after the input register
	typedef struct packed {
		logic        sample;
		logic [15:0] delta_vj;
		logic [15:0] delta_rfc;
	} sample_t;

	// configuration registers
	typedef struct packed {
		logic        mode_rfc793;
		logic [15:0] rto_min;
		logic [15:0] rto_max;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [31:0] smoothed_scaled;
		logic [15:0] variance_est;
		logic        updated;
	} result_t;

endpackage
`default_nettype wire

>>> hw/rtl/rte_in_stage.sv
// Input register of the RTT timeout estimator: takes a request and keeps the
// low 16 bits of both time differences. Depends on rte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rte_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       now_ms,
	input  wire logic [31:0]       send_time,
	input  wire logic              adv,
	output logic                   valid_s1,
	output rte_pkg::sample_t       item_s1
);

	logic             in_acc;
	logic [31:0]      diff_vj;
	logic [31:0]      diff_rfc;
	rte_pkg::sample_t item_d;

	// full and not moving on: hold the upstream
	assign in_stall = valid_s1 & ~adv;
	assign in_acc   = in_valid & ~in_stall;

	// only the low 16 bits of either difference are ever used
	always_comb begin
		diff_vj          = now_ms - send_time;
		diff_rfc         = now_ms - {send_time[31:1], 1'b0};
		item_d.sample    = (send_time != 32'd0);
		item_d.delta_vj  = diff_vj[15:0];
		item_d.delta_rfc = diff_rfc[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rte_update.sv
// Estimator state and its combinational update for both modes (Van Jacobson and
// RFC793 smoothing). Depends on rte_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rte_update (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire rte_pkg::sample_t  item,
	input  wire rte_pkg::cfg_t     cfg,
	output rte_pkg::result_t       res
);

	logic [31:0] srtt_q;
	logic [15:0] var_q;
	logic [15:0] rto_q;

	logic [15:0] m1, m_abs, m2;
	logic [31:0] srtt_vj;
	logic [15:0] var_vj, rto_vj;
	logic [rte_pkg::SUM_W-1:0]   sum_rfc;
	logic [2*rte_pkg::SUM_W-1:0] prod_rfc;
	logic [rte_pkg::QUO_W-1:0]   quo, clamped;
	logic [31:0] srtt_nx;
	logic [15:0] var_nx, rto_nx;

	// Van Jacobson: error against srtt/8, then variation against rttvar/4
	always_comb begin
		m1      = item.delta_vj - srtt_q[18:3];
		srtt_vj = srtt_q + {{16{m1[15]}}, m1};
		// most negative error wraps to itself
		m_abs   = m1[15] ? (16'd0 - m1) : m1;
		m2      = m_abs - {2'b00, var_q[15:2]};
		var_vj  = var_q + m2;
		rto_vj  = srtt_vj[18:3] + var_vj;
	end

	// RFC793: (4*delta + 8*rto) / 10 by reciprocal, then clamp (max bound wins)
	always_comb begin
		sum_rfc  = {2'b00, item.delta_rfc, 2'b00} + {1'b0, rto_q, 3'b000};
		prod_rfc = sum_rfc * rte_pkg::RECIP_TEN;
		quo      = prod_rfc[2*rte_pkg::SUM_W-1:rte_pkg::RECIP_SHIFT];
		clamped  = quo;
		if (clamped < {1'b0, cfg.rto_min}) begin
			clamped = {1'b0, cfg.rto_min};
		end
		if (clamped > {1'b0, cfg.rto_max}) begin
			clamped = {1'b0, cfg.rto_max};
		end
	end

	// next state; a zero timestamp leaves everything alone
	always_comb begin
		srtt_nx = srtt_q;
		var_nx  = var_q;
		rto_nx  = rto_q;
		if (item.sample) begin
			if (cfg.mode_rfc793) begin
				rto_nx = clamped[15:0];
			end else begin
				srtt_nx = srtt_vj;
				var_nx  = var_vj;
				rto_nx  = rto_vj;
			end
		end
		res.timeout_ms      = rto_nx;
		res.smoothed_scaled = srtt_nx;
		res.variance_est    = var_nx;
		res.updated         = item.sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q <= '0;
			var_q  <= '0;
			rto_q  <= '0;
		end else if (adv) begin
			srtt_q <= srtt_nx;
			var_q  <= var_nx;
			rto_q  <= rto_nx;
		end
	end

	// state moves only on an advancing request that carries a sample
	`ASSERT_NEXT(a_hold_idle, clk, arst_n, !adv,
		$stable(srtt_q) && $stable(var_q) && $stable(rto_q))
	`ASSERT_NEXT(a_hold_nosample, clk, arst_n, adv && !item.sample,
		$stable(srtt_q) && $stable(var_q) && $stable(rto_q))
	// RFC793 mode never touches the smoothed RTT or the variation
	`ASSERT_NEXT(a_rfc_keeps_vj, clk, arst_n, adv && cfg.mode_rfc793,
		$stable(srtt_q) && $stable(var_q))
	// RFC793 timeout lands inside a well-ordered clamp window
	`ASSERT_NEXT(a_rfc_clamp, clk, arst_n,
		adv && item.sample && cfg.mode_rfc793 && (cfg.rto_min <= cfg.rto_max),
		(rto_q >= $past(cfg.rto_min)) && (rto_q <= $past(cfg.rto_max)))

endmodule
`default_nettype wire

>>> hw/rtl/rte_out_stage.sv
// Result register of the RTT timeout estimator: holds one result until taken.
// Depends on rte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rte_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire rte_pkg::result_t  res,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic                   out_free,
	output logic [15:0]            timeout_ms,
	output logic [31:0]            smoothed_scaled,
	output logic [15:0]            variance_est,
	output logic                   updated
);

	rte_pkg::result_t result_s2;

	// room for a new result when empty or being taken this cycle
	assign out_free = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= res;
		end
	end

	assign timeout_ms      = result_s2.timeout_ms;
	assign smoothed_scaled = result_s2.smoothed_scaled;
	assign variance_est    = result_s2.variance_est;
	assign updated         = result_s2.updated;

endmodule
`default_nettype wire

>>> hw/rtl/tcp_rtt_timeout_estimator.sv
// Top level of the TCP RTT / retransmission timeout estimator.
// Uses rte_pkg, rte_in_stage, rte_update and rte_out_stage.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | sink      | in_valid / in_stall  | now_ms, send_time
//   out     | source    | out_valid / out_stall| timeout_ms, smoothed_scaled, variance_est,
//           |           |                      | updated
//   cfg     | sink      | cfg_we               | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; a result is offered once
// its request has moved from the input register into the result register.
// The input register feeds combinational update logic (RFC793 path: a 20x20 constant
// multiply for the divide by ten) that writes the state and the result register.
// Reset clears the estimator state to zero and loads the configuration defaults.
// A stalled result holds; one more request is taken and held behind it.
`timescale 1ns / 1ps
`default_nettype none
module tcp_rtt_timeout_estimator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic [31:0] send_time,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      timeout_ms,
	output logic [31:0]      smoothed_scaled,
	output logic [15:0]      variance_est,
	output logic             updated,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	rte_pkg::cfg_t    cfg_q;
	rte_pkg::sample_t item_s1;
	rte_pkg::result_t res;
	logic             valid_s1;
	logic             out_free;
	logic             adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_rfc793 <= 1'b0;
			cfg_q.rto_min     <= rte_pkg::RTO_MIN_RST;
			cfg_q.rto_max     <= rte_pkg::RTO_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rte_pkg::REG_MODE: begin
					cfg_q.mode_rfc793 <= cfg_data[0];
				end
				rte_pkg::REG_RTO_MIN: begin
					cfg_q.rto_min <= cfg_data;
				end
				rte_pkg::REG_RTO_MAX: begin
					cfg_q.rto_max <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// request in the input register moves on when the result register has room
	assign adv = valid_s1 & out_free;

	rte_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.now_ms    (now_ms),
		.send_time (send_time),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	rte_update u_upd (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	rte_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.res             (res),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.out_free        (out_free),
		.timeout_ms      (timeout_ms),
		.smoothed_scaled (smoothed_scaled),
		.variance_est    (variance_est),
		.updated         (updated)
	);

endmodule
`default_nettype wire
